// ===== rtl/u2u_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder: byte
// classes, UTF-16 surrogate constants and the job word passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package u2u_pkg;

    typedef enum logic [2:0] {
        CLS_CONT,
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } byte_class_t;

    localparam logic [15:0] REPLACEMENT_RESET = 16'h003F;
    localparam logic [20:0] SURR_BASE         = 21'h010000;
    localparam logic [15:0] HIGH_SURR         = 16'hD800;
    localparam logic [15:0] LOW_SURR          = 16'hDC00;

    // one job: rep_count replacement units, then tail_count decoded units
    typedef struct packed {
        logic [2:0]  rep_count;
        logic [1:0]  tail_count;
        logic [15:0] tail_first;
        logic [15:0] tail_second;
        logic        eos;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic byte_class_t classify(input logic [4:0] top_bits);
        byte_class_t cls;
        if (!top_bits[4])
            cls = CLS_ASCII;
        else if (!top_bits[3])
            cls = CLS_CONT;
        else if (!top_bits[2])
            cls = CLS_LEAD2;
        else if (!top_bits[1])
            cls = CLS_LEAD3;
        else if (!top_bits[0])
            cls = CLS_LEAD4;
        else
            cls = CLS_BAD;
        return cls;
    endfunction

endpackage

// ===== rtl/u2u_front.sv =====
// ----------------------------------------------------------------------------
// u2u_front
// Front end: accepts one byte per cycle unless full, tracks the open sequence
// and turns each byte into a job word of replacement and decoded code units.
// ----------------------------------------------------------------------------
module u2u_front
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  byte_value,
    input  logic        end_of_string,
    output job_t        job,
    output logic        job_push
);

    logic [2:0]  exp_len_reg;
    logic [2:0]  exp_len_next;
    logic [1:0]  taken_reg;
    logic [1:0]  taken_next;
    logic [20:0] cp_reg;
    logic [20:0] cp_next;

    byte_class_t cls;
    logic [2:0]  lead_len;
    logic [20:0] lead_payload;
    logic        lead_open;
    logic        lead_rep;
    logic [2:0]  taken_inc;
    logic [20:0] cont_cp;
    logic [20:0] surr_v;
    logic        accept;

    assign accept = push && !full;

    always_comb
    begin
        cls          = classify(byte_value[7:3]);
        lead_len     = 3'd0;
        lead_payload = '0;
        case (cls)
            CLS_LEAD2:
            begin
                lead_len     = 3'd2;
                lead_payload = {16'd0, byte_value[4:0]};
            end
            CLS_LEAD3:
            begin
                lead_len     = 3'd3;
                lead_payload = {17'd0, byte_value[3:0]};
            end
            CLS_LEAD4:
            begin
                lead_len     = 3'd4;
                lead_payload = {18'd0, byte_value[2:0]};
            end
            default:
            begin
                lead_len     = 3'd0;
                lead_payload = '0;
            end
        endcase

        lead_open = (lead_len != 3'd0) && !end_of_string;
        lead_rep  = !lead_open && (cls != CLS_ASCII);
        taken_inc = {1'b0, taken_reg} + 3'd1;
        cont_cp   = {cp_reg[14:0], byte_value[5:0]};
        surr_v    = cont_cp - SURR_BASE;

        job          = '0;
        job.eos      = end_of_string;
        exp_len_next = exp_len_reg;
        taken_next   = taken_reg;
        cp_next      = cp_reg;

        if ((exp_len_reg != 3'd0) && (cls == CLS_CONT))
        begin
            if (taken_inc >= exp_len_reg)
            begin
                if (cont_cp[20:16] == 5'd0)
                begin
                    job.tail_count = 2'd1;
                    job.tail_first = cont_cp[15:0];
                end
                else
                begin
                    job.tail_count  = 2'd2;
                    job.tail_first  = HIGH_SURR + {5'd0, surr_v[20:10]};
                    job.tail_second = LOW_SURR + {6'd0, surr_v[9:0]};
                end
                exp_len_next = 3'd0;
                taken_next   = 2'd0;
                cp_next      = '0;
            end
            else if (end_of_string)
            begin
                job.rep_count = taken_inc;
                exp_len_next  = 3'd0;
                taken_next    = 2'd0;
                cp_next       = '0;
            end
            else
            begin
                taken_next = taken_reg + 2'd1;
                cp_next    = cont_cp;
            end
        end
        else
        begin
            // broken sequence flush, then the byte as a fresh lead
            job.rep_count = {1'b0, taken_reg} + {2'd0, lead_rep};
            if (cls == CLS_ASCII)
            begin
                job.tail_count = 2'd1;
                job.tail_first = {8'd0, byte_value};
            end
            if (lead_open)
            begin
                exp_len_next = lead_len;
                taken_next   = 2'd1;
                cp_next      = lead_payload;
            end
            else
            begin
                exp_len_next = 3'd0;
                taken_next   = 2'd0;
                cp_next      = '0;
            end
        end

        if (end_of_string)
        begin
            exp_len_next = 3'd0;
            taken_next   = 2'd0;
            cp_next      = '0;
        end

        job_push = accept && ((job.rep_count != 3'd0) || (job.tail_count != 2'd0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= 3'd0;
            taken_reg   <= 2'd0;
            cp_reg      <= '0;
        end
        else if (accept)
        begin
            exp_len_reg <= exp_len_next;
            taken_reg   <= taken_next;
            cp_reg      <= cp_next;
        end
    end

endmodule

// ===== rtl/u2u_queue.sv =====
// ----------------------------------------------------------------------------
// u2u_queue
// Small first-in first-out queue of job words between front and back end.
// ----------------------------------------------------------------------------
module u2u_queue
    import u2u_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  job_t          wr_job,
    input  logic          rd_en,
    output job_t          rd_job,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_job       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

// ===== rtl/u2u_back.sv =====
// ----------------------------------------------------------------------------
// u2u_back
// Back end: holds one job word and hands out its code units one word per
// cycle while pop is high, replacements first, then the decoded units;
// holds the replacement register.
// ----------------------------------------------------------------------------
module u2u_back
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  job_t        head_job,
    input  logic        queue_empty,
    output logic        queue_take,
    output logic [15:0] code_unit,
    output logic        run_last,
    output logic        string_last,
    output logic        empty,
    input  logic        pop
);

    logic [15:0] repl_reg;
    job_t        job_reg;
    logic        have_reg;
    logic        have_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic [2:0]  total;
    logic [2:0]  tail_idx;
    logic        last_word;
    logic        load;

    always_comb
    begin
        total     = job_reg.rep_count + {1'b0, job_reg.tail_count};
        tail_idx  = idx_reg - job_reg.rep_count;
        last_word = (idx_reg + 3'd1) == total;

        if (idx_reg < job_reg.rep_count)
            code_unit = repl_reg;
        else if (tail_idx == 3'd0)
            code_unit = job_reg.tail_first;
        else
            code_unit = job_reg.tail_second;

        run_last    = last_word;
        string_last = last_word && job_reg.eos;
        empty       = !have_reg;

        load       = (!have_reg || (pop && last_word)) && !queue_empty;
        queue_take = load;

        have_next = have_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            have_next = 1'b1;
            idx_next  = 3'd0;
        end
        else if (have_reg && pop)
        begin
            if (last_word)
            begin
                have_next = 1'b0;
                idx_next  = 3'd0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg <= REPLACEMENT_RESET;
            have_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            if (cfg_write)
                repl_reg <= cfg_data;
            have_reg <= have_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= head_job;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |-> (total != 3'd0) && (idx_reg < total))
        else $error("word index outside held job");

    assert property (@(posedge clk) disable iff (!rst_n)
        (have_reg && !pop) |=> have_reg && $stable(idx_reg))
        else $error("held word moved without pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (have_reg && pop && last_word && queue_empty) |=> !have_reg)
        else $error("finished job still shown");
`endif

endmodule

// ===== rtl/utf8_to_utf16_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// Streaming UTF-8 to UTF-16 transcoder, one byte in, up to four code units
// out, with a configurable replacement unit for undecodable bytes.
// ----------------------------------------------------------------------------
// Input channel: byte_value and end_of_string are taken at an edge with push
// high and full low; one byte per cycle is taken while the job queue has room.
// Output channel: code_unit, run_last and string_last show the oldest word
// while empty is low; it leaves at an edge with pop high.
// A byte yields zero to four words: run_last marks the last one of a byte and
// string_last the final word of a string.
// The first word of a byte shows once its job has passed through the queue
// and the back end has loaded it into its job register.
// Throughput: one byte per cycle in while full is low, one word per cycle
// out while pop is high; a byte of several words holds the back end until
// all are popped; the QUEUE_DEPTH job queue absorbs bursts before full rises.
// When pop stays low the queue fills and full stops further bytes.
// Reset empties the queue, closes any open sequence and sets the
// replacement unit to '?'. cfg_write loads the replacement unit from cfg_data.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit
    import u2u_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_value,
    input  logic        end_of_string,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] code_unit,
    output logic        run_last,
    output logic        string_last
);

    job_t          front_job;
    logic          front_push;
    job_t          head_job;
    logic          queue_take;
    queue_status_t queue_status;

    assign full = queue_status.full;

    u2u_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (queue_status.full),
        .byte_value    (byte_value),
        .end_of_string (end_of_string),
        .job           (front_job),
        .job_push      (front_push)
    );

    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_push),
        .wr_job (front_job),
        .rd_en  (queue_take),
        .rd_job (head_job),
        .status (queue_status)
    );

    u2u_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .head_job    (head_job),
        .queue_empty (queue_status.empty),
        .queue_take  (queue_take),
        .code_unit   (code_unit),
        .run_last    (run_last),
        .string_last (string_last),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// ===== dv/utf16_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf16_stream_checker
// Watches the byte, word and replacement-unit channels of the transcoder,
// decodes every accepted byte into the UTF-16 words it must give, and compares
// each popped word field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module utf16_stream_checker
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  byte_value,
    input  logic        end_of_string,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] code_unit,
    input  logic        run_last,
    input  logic        string_last,
    output int          error_count,
    output int          words_pending
);

    typedef struct packed {
        logic [15:0] unit;
        logic        run_end;
        logic        string_end;
    } utf16_word_t;

    logic [15:0] rep_unit = REPLACEMENT_RESET;
    logic [2:0]  seq_len = '0;
    logic [1:0]  seq_taken = '0;
    logic [20:0] seq_cp = '0;

    logic [15:0] byte_units[$];
    utf16_word_t expected_words[$];

    initial
    begin
        error_count = 0;
        words_pending = 0;
    end

    function automatic byte_class_t class_of(input logic [7:0] b);
        byte_class_t cls;
        if (!b[7])
            cls = CLS_ASCII;
        else if (!b[6])
            cls = CLS_CONT;
        else if (!b[5])
            cls = CLS_LEAD2;
        else if (!b[4])
            cls = CLS_LEAD3;
        else if (!b[3])
            cls = CLS_LEAD4;
        else
            cls = CLS_BAD;
        return cls;
    endfunction

    task automatic drop_sequence();
        seq_len = '0;
        seq_taken = '0;
        seq_cp = '0;
    endtask

    task automatic emit_codepoint(input logic [20:0] cp);
        logic [20:0] v;
        if (cp < SURR_BASE)
        begin
            byte_units.push_back(cp[15:0]);
        end
        else
        begin
            v = cp - SURR_BASE;
            byte_units.push_back(HIGH_SURR + {5'b0, v[20:10]});
            byte_units.push_back(LOW_SURR + {6'b0, v[9:0]});
        end
    endtask

    task automatic open_or_emit(input logic [7:0] b, input logic eos, input byte_class_t cls);
        case (cls)
            CLS_ASCII:
            begin
                byte_units.push_back({8'h00, b});
            end
            CLS_LEAD2, CLS_LEAD3, CLS_LEAD4:
            begin
                if (eos)
                begin
                    byte_units.push_back(rep_unit);
                end
                else
                begin
                    seq_taken = 2'd1;
                    case (cls)
                        CLS_LEAD2:
                        begin
                            seq_len = 3'd2;
                            seq_cp = 21'(b[4:0]);
                        end
                        CLS_LEAD3:
                        begin
                            seq_len = 3'd3;
                            seq_cp = 21'(b[3:0]);
                        end
                        default:
                        begin
                            seq_len = 3'd4;
                            seq_cp = 21'(b[2:0]);
                        end
                    endcase
                end
            end
            default:
            begin
                byte_units.push_back(rep_unit);
            end
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eos);
        byte_class_t cls;
        utf16_word_t w;
        cls = class_of(b);
        byte_units.delete();
        if (seq_len != 0)
        begin
            if (cls == CLS_CONT)
            begin
                seq_cp = {seq_cp[14:0], b[5:0]};
                if (int'(seq_taken) + 1 >= int'(seq_len))
                begin
                    emit_codepoint(seq_cp);
                    drop_sequence();
                end
                else if (eos)
                begin
                    // cut off: one unit per byte of the sequence, this one included
                    repeat (int'(seq_taken) + 1) byte_units.push_back(rep_unit);
                    drop_sequence();
                end
                else
                begin
                    seq_taken = seq_taken + 2'd1;
                end
            end
            else
            begin
                // broken sequence, then retry this byte as a lead
                repeat (int'(seq_taken)) byte_units.push_back(rep_unit);
                drop_sequence();
                open_or_emit(b, eos, cls);
            end
        end
        else
        begin
            open_or_emit(b, eos, cls);
        end
        if (eos)
            drop_sequence();
        foreach (byte_units[i])
        begin
            w.unit = byte_units[i];
            w.run_end = (i == byte_units.size() - 1);
            w.string_end = w.run_end && eos;
            expected_words.push_back(w);
        end
    endtask

    task automatic check_word();
        utf16_word_t w;
        if (expected_words.size() == 0)
        begin
            $error("unexpected word: code_unit %h run_last %b string_last %b",
                   code_unit, run_last, string_last);
            error_count++;
        end
        else
        begin
            w = expected_words.pop_front();
            if (code_unit !== w.unit)
            begin
                $error("code_unit: expected %h, actual %h", w.unit, code_unit);
                error_count++;
            end
            if (run_last !== w.run_end)
            begin
                $error("run_last: expected %b, actual %b", w.run_end, run_last);
                error_count++;
            end
            if (string_last !== w.string_end)
            begin
                $error("string_last: expected %b, actual %b", w.string_end, string_last);
                error_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_unit = REPLACEMENT_RESET;
            drop_sequence();
            expected_words.delete();
            words_pending <= 0;
        end
        else
        begin
            if (pop && !empty)
                check_word();
            if (cfg_write)
                rep_unit = cfg_data;
            if (push && !full)
                decode_byte(byte_value, end_of_string);
            words_pending <= expected_words.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream testbench for the UTF-8 to UTF-16 transcoder: a directed run
// over field extremes and malformed-input cases, then random strings of
// mostly well-formed characters under four replacement units, with random
// idling on both sides, a long receiver stall and a stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import u2u_pkg::*;

    localparam int RX_HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BYTES    = 99;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  byte_value = '0;
    logic        end_of_string = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_last;

    int mismatch_count;
    int words_pending;
    int bytes_sent = 0;
    bit steady = 1'b0;
    bit rx_hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    utf8_to_utf16_transcoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .byte_value    (byte_value),
        .end_of_string (end_of_string),
        .empty         (empty),
        .pop           (pop),
        .code_unit     (code_unit),
        .run_last      (run_last),
        .string_last   (string_last)
    );

    utf16_stream_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .byte_value    (byte_value),
        .end_of_string (end_of_string),
        .empty         (empty),
        .pop           (pop),
        .code_unit     (code_unit),
        .run_last      (run_last),
        .string_last   (string_last),
        .error_count   (mismatch_count),
        .words_pending (words_pending)
    );

    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] b;
        case (len)
            2:       b = {3'b110, 5'($urandom)};
            3:       b = {4'b1110, 4'($urandom)};
            default: b = {5'b11110, 3'($urandom)};
        endcase
        return b;
    endfunction

    function automatic logic [7:0] trail_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos);
        while (!steady && $urandom_range(99, 0) < 28)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        byte_value <= b;
        end_of_string <= eos;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
    endtask

    // one character, mostly well formed, sometimes stray, bad or truncated
    task automatic send_char(input bit last_of_string);
        logic [7:0] char_bytes[$];
        int kind;
        int len;
        kind = $urandom_range(99, 0);
        if (kind < 30)
        begin
            char_bytes.push_back(8'($urandom_range(8'h7F, 0)));
        end
        else if (kind < 80)
        begin
            len = (kind < 50) ? 2 : (kind < 65) ? 3 : 4;
            char_bytes.push_back(lead_byte(len));
            repeat (len - 1) char_bytes.push_back(trail_byte());
        end
        else if (kind < 88)
        begin
            if (kind[0])
                char_bytes.push_back(trail_byte());
            else
                char_bytes.push_back(8'($urandom_range(8'hFF, 8'hF8)));
        end
        else if (kind < 95)
        begin
            len = $urandom_range(4, 2);
            char_bytes.push_back(lead_byte(len));
            repeat ($urandom_range(len - 2, 0)) char_bytes.push_back(trail_byte());
        end
        else
        begin
            char_bytes.push_back(8'($urandom));
        end
        foreach (char_bytes[i])
            send_byte(char_bytes[i], last_of_string && (i == char_bytes.size() - 1));
    endtask

    task automatic send_strings(input int n_bytes);
        int target;
        int chars;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            chars = $urandom_range(12, 1);
            for (int c = 0; c < chars; c++)
                send_char(c == chars - 1);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_replacement(input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : receiver
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            pop <= steady || ($urandom_range(99, 0) >= 28);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL utf8_to_utf16_transcoder_unit");
        $finish;
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes and well-formed sequences of every length
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // beyond the unicode range, surrogate pair closing a string
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // bad lead, stray continuation
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        // broken sequence retried as ascii
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        // three bytes taken, then broken by a bad lead: four words
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        // sequence cut off at end of string, lead carrying end of string
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hC3, 1'b1);
        wait_drained();

        write_replacement(16'hFFFD);
        send_strings(PHASE_BYTES);
        wait_drained();

        // receiver stalls while bytes keep coming
        write_replacement(16'hFFFF);
        rx_hold_req = 1'b1;
        send_strings(PHASE_BYTES);
        wait_drained();

        // full rate on both sides
        write_replacement(16'h0000);
        steady = 1'b1;
        send_strings(PHASE_BYTES);
        steady = 1'b0;
        wait_drained();

        write_replacement(16'($urandom));
        send_strings(PHASE_BYTES);
        wait_drained();

        if (mismatch_count == 0 && words_pending == 0)
            $display("PASS utf8_to_utf16_transcoder_unit");
        else
            $display("FAIL utf8_to_utf16_transcoder_unit");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/u2u_pkg.sv
rtl/u2u_front.sv
rtl/u2u_queue.sv
rtl/u2u_back.sv
rtl/utf8_to_utf16_transcoder_unit.sv
dv/utf16_stream_checker.sv
dv/tb_top.sv
